### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every sampled edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons must hold at the same edge as ante
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// cons must hold at the edge after ante
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [15:0] HEAP_RESET = 16'd20000;

  localparam logic REG_HEAP_SIZE = 1'b0;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_FULL    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_ZERO    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_WB   = 3'b100
  } state_t;

endpackage

`default_nettype wire

### rtl/ffba_cell.sv
`default_nettype none

module ffba_cell #(
  parameter int ADDR_BITS = 16,
  parameter int IDX_W = 5,
  parameter int IDX = 0,
  parameter type tok_t = logic,
  parameter type cmd_t = logic
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 init,
  input  logic [ADDR_BITS-1:0] init_len,
  input  cmd_t                 cmd,
  input  logic                 tin_valid,
  input  tok_t                 tin,
  output logic                 tout_valid,
  output tok_t                 tout
);
  import ffba_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [ADDR_BITS-1:0] start;
  logic [ADDR_BITS-1:0] len;
  logic                 fr;
  logic                 iu;
  logic [ADDR_BITS:0]   end_sum;
  tok_t                 tok_next;

  assign end_sum = {1'b0, start} + {1'b0, len};

  always_comb begin
    tok_next = tin;
    if (tin.op == OP_ALLOC) begin
      if (!iu) begin
        if (!tin.spare_ok) begin
          tok_next.spare_ok  = 1'b1;
          tok_next.spare_idx = MY_IDX;
        end
      end else if (fr && len >= tin.req) begin
        if (!tin.fit_ok || start < tin.fit_start) begin
          tok_next.fit_ok    = 1'b1;
          tok_next.fit_idx   = MY_IDX;
          tok_next.fit_start = start;
          tok_next.fit_len   = len;
        end
      end
    end else begin
      if (iu && !fr && start == tin.addr && !tin.hit_ok) begin
        tok_next.hit_ok  = 1'b1;
        tok_next.hit_idx = MY_IDX;
        tok_next.hit_len = len;
      end
      if (iu && fr && end_sum == {1'b0, tin.addr} && !tin.bef_ok) begin
        tok_next.bef_ok    = 1'b1;
        tok_next.bef_idx   = MY_IDX;
        tok_next.bef_start = start;
        tok_next.bef_len   = len;
      end
      if (iu && start > tin.addr && (!tin.nxt_ok || start < tin.nxt_start)) begin
        tok_next.nxt_ok    = 1'b1;
        tok_next.nxt_idx   = MY_IDX;
        tok_next.nxt_start = start;
        tok_next.nxt_len   = len;
        tok_next.nxt_free  = fr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (init) begin
      start <= '0;
      len   <= (IDX == 0) ? init_len : '0;
      fr    <= (IDX == 0);
      iu    <= (IDX == 0);
    end else if (cmd.w0.en && cmd.w0.idx == MY_IDX) begin
      start <= cmd.w0.start;
      len   <= cmd.w0.len;
      fr    <= cmd.w0.fr;
      iu    <= cmd.w0.iu;
    end else if (cmd.w1.en && cmd.w1.idx == MY_IDX) begin
      start <= cmd.w1.start;
      len   <= cmd.w1.len;
      fr    <= cmd.w1.fr;
      iu    <= cmd.w1.iu;
    end else if (cmd.w2.en && cmd.w2.idx == MY_IDX) begin
      start <= cmd.w2.start;
      len   <= cmd.w2.len;
      fr    <= cmd.w2.fr;
      iu    <= cmd.w2.iu;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout_valid <= 1'b0;
    end else begin
      tout_valid <= tin_valid;
    end
    if (tin_valid) begin
      tout <= tok_next;
    end
  end

endmodule

`default_nettype wire

### rtl/first_fit_block_allocator.sv
// An accepted item walks the descriptor chain one cell a cycle through the MAX_BLOCKS
// cell registers; the table is then written back in S_WB once the output can take the
// result, which is registered. No new item is taken until the write-back is done.
// Reset: synchronous; the table holds one free block of 20000 units.
// A write of heap_size rebuilds the table as one free block of the written size.
`default_nettype none

`include "assert_macros.svh"

module first_fit_block_allocator #(
  parameter int MAX_BLOCKS = 32,
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 operation,
  input  logic [ADDR_BITS-1:0] request_size,
  input  logic [ADDR_BITS-1:0] block_address,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           status,
  output logic [ADDR_BITS-1:0] granted_address
);
  import ffba_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int A = ADDR_BITS;

  typedef struct packed {
    logic             op;
    logic [A-1:0]     req;
    logic [A-1:0]     addr;
    logic             fit_ok;
    logic [IDX_W-1:0] fit_idx;
    logic [A-1:0]     fit_start;
    logic [A-1:0]     fit_len;
    logic             spare_ok;
    logic [IDX_W-1:0] spare_idx;
    logic             hit_ok;
    logic [IDX_W-1:0] hit_idx;
    logic [A-1:0]     hit_len;
    logic             bef_ok;
    logic [IDX_W-1:0] bef_idx;
    logic [A-1:0]     bef_start;
    logic [A-1:0]     bef_len;
    logic             nxt_ok;
    logic [IDX_W-1:0] nxt_idx;
    logic [A-1:0]     nxt_start;
    logic [A-1:0]     nxt_len;
    logic             nxt_free;
  } tok_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [A-1:0]     start;
    logic [A-1:0]     len;
    logic             fr;
    logic             iu;
  } wr_t;

  typedef struct packed {
    wr_t w0;
    wr_t w1;
    wr_t w2;
  } cmd_t;

  state_t      state;
  state_t      state_next;
  logic [15:0] heap_size;
  logic        cfg_wr;
  logic        init;
  logic [A-1:0] init_len;
  logic        commit;
  cmd_t        cmd;
  status_t     st_n;
  logic [A-1:0] gaddr_n;
  tok_t        chain [MAX_BLOCKS+1];
  logic        chain_v [MAX_BLOCKS+1];
  tok_t        tail;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_HEAP_SIZE);
  assign init     = rst || cfg_wr;
  assign init_len = rst ? A'(HEAP_RESET) : A'(pwdata[15:0]);
  assign prdata   = (paddr[2] == REG_HEAP_SIZE) ? {16'b0, heap_size} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_size <= HEAP_RESET;
    end else if (cfg_wr) begin
      heap_size <= pwdata[15:0];
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    chain[0]      = '0;
    chain[0].op   = operation;
    chain[0].req  = request_size;
    chain[0].addr = block_address;
  end
  assign chain_v[0] = in_valid && in_ready;

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    ffba_cell #(
      .ADDR_BITS(A),
      .IDX_W(IDX_W),
      .IDX(i),
      .tok_t(tok_t),
      .cmd_t(cmd_t)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .init(init),
      .init_len(init_len),
      .cmd(cmd),
      .tin_valid(chain_v[i]),
      .tin(chain[i]),
      .tout_valid(chain_v[i+1]),
      .tout(chain[i+1])
    );
  end

  assign tail   = chain[MAX_BLOCKS];
  assign commit = (state == S_WB) && (!out_valid || out_ready);

  always_comb begin
    logic         after;
    logic [A-1:0] merged;
    after   = tail.nxt_ok && tail.nxt_free;
    merged  = tail.hit_len + (after ? tail.nxt_len : '0);
    cmd     = '0;
    st_n    = ST_OK;
    gaddr_n = '0;
    if (tail.op == OP_ALLOC) begin
      priority if (tail.req == '0) begin
        st_n = ST_ZERO;
      end else if (!tail.fit_ok) begin
        st_n = ST_NOFIT;
      end else if (tail.fit_len == tail.req) begin
        cmd.w0  = '{1'b1, tail.fit_idx, tail.fit_start, tail.fit_len, 1'b0, 1'b1};
        gaddr_n = tail.fit_start;
      end else if (!tail.spare_ok) begin
        st_n = ST_FULL;
      end else begin
        cmd.w0  = '{1'b1, tail.fit_idx, tail.fit_start + tail.req,
                    tail.fit_len - tail.req, 1'b1, 1'b1};
        cmd.w1  = '{1'b1, tail.spare_idx, tail.fit_start, tail.req, 1'b0, 1'b1};
        gaddr_n = tail.fit_start;
      end
    end else begin
      if (!tail.hit_ok) begin
        st_n = ST_UNKNOWN;
      end else begin
        if (tail.bef_ok) begin
          cmd.w0 = '{1'b1, tail.bef_idx, tail.bef_start, tail.bef_len + merged, 1'b1, 1'b1};
          cmd.w1 = '{1'b1, tail.hit_idx, '0, '0, 1'b0, 1'b0};
        end else begin
          cmd.w0 = '{1'b1, tail.hit_idx, tail.addr, merged, 1'b1, 1'b1};
        end
        if (after) begin
          cmd.w2 = '{1'b1, tail.nxt_idx, '0, '0, 1'b0, 1'b0};
        end
      end
    end
    if (!commit) begin
      cmd.w0.en = 1'b0;
      cmd.w1.en = 1'b0;
      cmd.w2.en = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_SCAN;
      S_SCAN: if (chain_v[MAX_BLOCKS]) state_next = S_WB;
      S_WB:   if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (commit) begin
      status          <= st_n;
      granted_address <= gaddr_n;
    end
  end

  `ASSERT_IMPL(a_tail_in_scan, clk, rst, chain_v[MAX_BLOCKS], state == S_SCAN,
               "query left the chain outside a scan")
  `ASSERT_NEXT(a_commit_shows, clk, rst, commit, out_valid, "committed item not presented")
  `ASSERT_IMPL(a_grant_only_ok, clk, rst, out_valid && status != ST_OK,
               granted_address == '0, "address granted on a failed item")

endmodule

`default_nettype wire
